/* hw/rtl/hpn_pkg.sv */
// ----------------------------------------------------------------------------
// hpn_pkg: shared definitions for the hash pixel noise block
// Mixing constants, widths, register indexes and the partial-product helper.
// ----------------------------------------------------------------------------
`default_nettype none

package hpn_pkg;

   localparam int COORD_BITS = 12;
   // Lane column is up to 3x+2, so two extra bits.
   localparam int LANE_X_BITS = COORD_BITS + 2;
   localparam int MIX_STEPS = 5;
   // Two register stages for each of the five multiply steps.
   localparam int HASH_LAT = 2 * MIX_STEPS;

   localparam logic [63:0] MIX_A = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_B = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_C = 64'h94D049BB133111EB;

   localparam logic [23:0] NOISE_SPAN = 24'hFFFFFF;
   // Half of NOISE_SPAN * 32768, added before the divide for rounding.
   localparam logic [56:0] HALF_DEN = 57'(64'hFFFFFF * 64'd16384);

   typedef enum logic [2:0] {
      REG_AMOUNT  = 3'd0,
      REG_SEED    = 3'd1,
      REG_FRAME   = 3'd2,
      REG_PER_CH  = 3'd3,
      REG_X_START = 3'd4,
      REG_X_END   = 3'd5,
      REG_Y_START = 3'd6,
      REG_Y_END   = 3'd7
   } csr_index_type;

   // Partial products of a 64 x 64 multiply kept modulo 2^64.
   typedef struct packed {
      logic [63:0] lo;
      logic [31:0] mid;
   } mul_part_type;

   function automatic mul_part_type mul_parts(input logic [63:0] a, input logic [63:0] b);
      mul_part_type p;
      logic [31:0] cross_a;
      logic [31:0] cross_b;
      p.lo = 64'(a[31:0]) * 64'(b[31:0]);
      cross_a = a[63:32] * b[31:0];
      cross_b = a[31:0] * b[63:32];
      p.mid = cross_a + cross_b;
      return p;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/hpn_hash_lane.sv */
// ----------------------------------------------------------------------------
// hpn_hash_lane: pipelined coordinate hash
// Five multiply-add steps, each split into a partial-product stage and a sum
// stage; the low 32 bits of the final mix leave after a last xor-shift.
// ----------------------------------------------------------------------------
`default_nettype none

module hpn_hash_lane (
   input  wire logic                           clock,
   input  wire logic [hpn_pkg::LANE_X_BITS-1:0] lane_x,
   input  wire logic [hpn_pkg::COORD_BITS-1:0]  lane_y,
   input  wire logic [31:0]                     seed,
   input  wire logic [31:0]                     frame,
   output      logic [31:0]                     hash_out
);

   hpn_pkg::mul_part_type              part_ff [hpn_pkg::MIX_STEPS];
   logic [63:0]                        h_ff    [hpn_pkg::MIX_STEPS];
   logic [hpn_pkg::COORD_BITS-1:0]     y_ff;
   logic [63:0]                        mul_a   [hpn_pkg::MIX_STEPS];
   logic [63:0]                        mul_b   [hpn_pkg::MIX_STEPS];
   logic [63:0]                        addend  [hpn_pkg::MIX_STEPS];
   logic [63:0]                        h_last;

   always_comb begin
      mul_a[0]  = 64'(lane_x);
      mul_a[1]  = h_ff[0];
      mul_a[2]  = h_ff[1];
      mul_a[3]  = h_ff[2] ^ (h_ff[2] >> 30);
      mul_a[4]  = h_ff[3] ^ (h_ff[3] >> 27);
      mul_b[0]  = hpn_pkg::MIX_A;
      mul_b[1]  = hpn_pkg::MIX_B;
      mul_b[2]  = hpn_pkg::MIX_C;
      mul_b[3]  = hpn_pkg::MIX_B;
      mul_b[4]  = hpn_pkg::MIX_C;
      addend[0] = 64'(y_ff);
      addend[1] = 64'(seed);
      addend[2] = 64'(frame);
      addend[3] = 64'd0;
      addend[4] = 64'd0;
   end

   always_ff @(posedge clock) begin
      y_ff <= lane_y;
      for (int k = 0; k < hpn_pkg::MIX_STEPS; k++) begin
         part_ff[k] <= hpn_pkg::mul_parts(mul_a[k], mul_b[k]);
         h_ff[k]    <= part_ff[k].lo + {part_ff[k].mid, 32'd0} + addend[k];
      end
   end

   assign h_last   = h_ff[hpn_pkg::MIX_STEPS-1] ^ (h_ff[hpn_pkg::MIX_STEPS-1] >> 31);
   assign hash_out = h_last[31:0];

endmodule

`default_nettype wire

/* hw/rtl/hash_pixel_noise.sv */
// ----------------------------------------------------------------------------
// hash_pixel_noise: deterministic hash noise on premultiplied RGBA pixels
//
// A pixel transfer is taken when start is high and busy is low; busy never
// rises, so one pixel may enter on every clock. Each pixel gives exactly one
// result transfer, marked by rsp_valid for a single cycle. After an entry
// register stage, the pixel passes through the hash: five 64-bit multiply
// steps, each cut into a partial-product stage and a sum stage, followed by
// six stages that scale the noise by amount and alpha, divide by the fixed
// span and saturate. Throughput is one pixel per cycle. The receiver cannot
// hold results off, so nothing stalls and no buffering is needed. The csr
// port writes a register at any edge where csr_write_en is high; software
// writes only while no pixel is in flight. Synchronous reset clears the
// valid pipeline and restores the registers (clip ends to 4096, everything
// else zero).
// ----------------------------------------------------------------------------
`default_nettype none

module hash_pixel_noise (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [11:0] req_pixel_x,
   input  wire logic [11:0] req_pixel_y,
   input  wire logic [15:0] req_red_in,
   input  wire logic [15:0] req_green_in,
   input  wire logic [15:0] req_blue_in,
   input  wire logic [15:0] req_alpha_in,
   output      logic        rsp_valid,
   output      logic [15:0] rsp_red_out,
   output      logic [15:0] rsp_green_out,
   output      logic [15:0] rsp_blue_out,
   output      logic [15:0] rsp_alpha_out,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int S_MAG   = hpn_pkg::HASH_LAT + 1;
   localparam int S_SCALE = hpn_pkg::HASH_LAT + 2;
   localparam int S_PROD  = hpn_pkg::HASH_LAT + 3;
   localparam int S_DIV   = hpn_pkg::HASH_LAT + 4;
   localparam int S_QUOT  = hpn_pkg::HASH_LAT + 5;
   localparam int S_OUT   = hpn_pkg::HASH_LAT + 6;

   typedef struct packed {
      logic        proc;
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      logic [15:0] a;
   } pix_type;

   // Configuration registers.
   logic [15:0] amount_ff;
   logic [31:0] seed_ff;
   logic [31:0] frame_ff;
   logic        per_ch_ff;
   logic [12:0] x_start_ff;
   logic [12:0] x_end_ff;
   logic [12:0] y_start_ff;
   logic [12:0] y_end_ff;

   logic                               take;
   logic [hpn_pkg::COORD_BITS-1:0]     x_m;
   logic [hpn_pkg::COORD_BITS-1:0]     y_m;
   logic [hpn_pkg::LANE_X_BITS-1:0]    x_ext;
   logic [hpn_pkg::LANE_X_BITS-1:0]    x_three;
   logic [hpn_pkg::LANE_X_BITS-1:0]    lane_x_in [3];
   logic [hpn_pkg::LANE_X_BITS-1:0]    lane_x_ff [3];
   logic [hpn_pkg::COORD_BITS-1:0]     lane_y_ff;
   logic                               in_window;
   pix_type                            pix_in;
   logic [31:0]                        hash_w [3];

   logic    vld_ff [S_OUT+1];
   pix_type pix_ff [S_OUT];

   logic [23:0] mag_ff   [3];
   logic [39:0] scale_ff [3];
   logic [55:0] prod_ff  [3];
   logic [41:0] div_ff   [3];
   logic [18:0] quot_ff  [3];
   logic        neg_ff   [S_MAG:S_QUOT][3];

   logic [24:0] twice    [3];
   logic        neg_in   [3];
   logic [23:0] mag_in   [3];
   logic [56:0] round_in [3];
   logic [24:0] fold_in  [3];
   logic [18:0] quot_in  [3];
   logic [15:0] chan_c   [3];
   logic [15:0] chan_in  [3];
   logic [19:0] sum_in   [3];

   logic [15:0] red_ff;
   logic [15:0] green_ff;
   logic [15:0] blue_ff;
   logic [15:0] alpha_ff;

   assign busy = 1'b0;
   assign take = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         amount_ff  <= '0;
         seed_ff    <= '0;
         frame_ff   <= '0;
         per_ch_ff  <= 1'b0;
         x_start_ff <= '0;
         x_end_ff   <= 13'd4096;
         y_start_ff <= '0;
         y_end_ff   <= 13'd4096;
      end else if (csr_write_en) begin
         case (hpn_pkg::csr_index_type'(csr_index))
            hpn_pkg::REG_AMOUNT:  amount_ff  <= csr_wdata[15:0];
            hpn_pkg::REG_SEED:    seed_ff    <= csr_wdata;
            hpn_pkg::REG_FRAME:   frame_ff   <= csr_wdata;
            hpn_pkg::REG_PER_CH:  per_ch_ff  <= csr_wdata[0];
            hpn_pkg::REG_X_START: x_start_ff <= csr_wdata[12:0];
            hpn_pkg::REG_X_END:   x_end_ff   <= csr_wdata[12:0];
            hpn_pkg::REG_Y_START: y_start_ff <= csr_wdata[12:0];
            hpn_pkg::REG_Y_END:   y_end_ff   <= csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   // Entry stage: clip test, bypass decision and the column for each lane.
   // In grey mode all three lanes hash the plain column, so they agree.
   always_comb begin
      x_m     = req_pixel_x[hpn_pkg::COORD_BITS-1:0];
      y_m     = req_pixel_y[hpn_pkg::COORD_BITS-1:0];
      x_ext   = hpn_pkg::LANE_X_BITS'(x_m);
      x_three = hpn_pkg::LANE_X_BITS'(x_ext * 3);
      for (int k = 0; k < 3; k++) begin
         lane_x_in[k] = per_ch_ff ? hpn_pkg::LANE_X_BITS'(x_three + k) : x_ext;
      end
      in_window = (13'(x_m) >= x_start_ff) && (13'(x_m) < x_end_ff) &&
                  (13'(y_m) >= y_start_ff) && (13'(y_m) < y_end_ff);
      pix_in.proc = in_window && (req_alpha_in != 16'd0) && (amount_ff != 16'd0);
      pix_in.r    = req_red_in;
      pix_in.g    = req_green_in;
      pix_in.b    = req_blue_in;
      pix_in.a    = req_alpha_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= S_OUT; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else begin
         vld_ff[0] <= take;
         for (int s = 1; s <= S_OUT; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_ff[0] <= pix_in;
      lane_y_ff <= y_m;
      for (int k = 0; k < 3; k++) begin
         lane_x_ff[k] <= lane_x_in[k];
      end
      for (int s = 1; s < S_OUT; s++) begin
         pix_ff[s] <= pix_ff[s-1];
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_lane
      hpn_hash_lane u_lane (
         .clock    (clock),
         .lane_x   (lane_x_ff[k]),
         .lane_y   (lane_y_ff),
         .seed     (seed_ff),
         .frame    (frame_ff),
         .hash_out (hash_w[k])
      );
   end

   // Noise arithmetic. The signed noise is N = 2v - span with v the top
   // 24 bits of the hash; its magnitude is scaled by amount and alpha, then
   // divided by span * 32768 with rounding half away from zero.
   always_comb begin
      chan_c[0] = pix_ff[S_QUOT].r;
      chan_c[1] = pix_ff[S_QUOT].g;
      chan_c[2] = pix_ff[S_QUOT].b;
      for (int k = 0; k < 3; k++) begin
         twice[k]  = {hash_w[k][31:8], 1'b0};
         neg_in[k] = twice[k] < 25'(hpn_pkg::NOISE_SPAN);
         mag_in[k] = neg_in[k] ? 24'(25'(hpn_pkg::NOISE_SPAN) - twice[k])
                               : 24'(twice[k] - 25'(hpn_pkg::NOISE_SPAN));
         round_in[k] = 57'(prod_ff[k]) + hpn_pkg::HALF_DEN;
         // Dividing by 2^24 - 1: the quotient is the high part, plus one when
         // high and low parts together reach the divisor.
         fold_in[k] = 25'(div_ff[k][41:24]) + 25'(div_ff[k][23:0]);
         quot_in[k] = 19'(div_ff[k][41:24]) +
                      19'(fold_in[k] >= 25'(hpn_pkg::NOISE_SPAN));
         sum_in[k]  = 20'(chan_c[k]) + 20'(quot_ff[k]);
         if (!pix_ff[S_QUOT].proc) begin
            chan_in[k] = chan_c[k];
         end else if (neg_ff[S_QUOT][k]) begin
            chan_in[k] = (quot_ff[k] >= 19'(chan_c[k])) ? 16'd0
                       : 16'(19'(chan_c[k]) - quot_ff[k]);
         end else begin
            chan_in[k] = (sum_in[k] > 20'd65535) ? 16'hFFFF : sum_in[k][15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         mag_ff[k]          <= mag_in[k];
         neg_ff[S_MAG][k]   <= neg_in[k];
         scale_ff[k]        <= 40'(mag_ff[k]) * 40'(amount_ff);
         prod_ff[k]         <= 56'(scale_ff[k]) * 56'(pix_ff[S_SCALE].a);
         div_ff[k]          <= round_in[k][56:15];
         quot_ff[k]         <= quot_in[k];
         for (int s = S_MAG + 1; s <= S_QUOT; s++) begin
            neg_ff[s][k] <= neg_ff[s-1][k];
         end
      end
      red_ff   <= chan_in[0];
      green_ff <= chan_in[1];
      blue_ff  <= chan_in[2];
      alpha_ff <= pix_ff[S_QUOT].a;
   end

   assign rsp_valid     = vld_ff[S_OUT];
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_alpha_out = alpha_ff;

`ifndef SYNTHESIS
   // A taken pixel leaves after the full pipeline depth.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] |-> ##(S_OUT) rsp_valid)
      else $error("pixel did not leave after the pipeline depth");

   // Alpha is carried unchanged to the result.
   a_alpha: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_QUOT] |=> (rsp_alpha_out == $past(pix_ff[S_QUOT].a)))
      else $error("alpha changed on its way through");

   // A bypassed pixel leaves with its colour untouched.
   a_bypass: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[S_QUOT] && !pix_ff[S_QUOT].proc) |=>
         (rsp_red_out == $past(pix_ff[S_QUOT].r)) &&
         (rsp_green_out == $past(pix_ff[S_QUOT].g)) &&
         (rsp_blue_out == $past(pix_ff[S_QUOT].b)))
      else $error("bypassed pixel was altered");
`endif

endmodule

`default_nettype wire

/* test/hpn_checker.sv */
// ----------------------------------------------------------------------------
// hpn_checker: result checker for the hash pixel noise block
// Watches the pixel and register channels, predicts each result pixel and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpn_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [11:0] req_pixel_x,
   input  wire logic [11:0] req_pixel_y,
   input  wire logic [15:0] req_red_in,
   input  wire logic [15:0] req_green_in,
   input  wire logic [15:0] req_blue_in,
   input  wire logic [15:0] req_alpha_in,
   input  wire logic        rsp_valid,
   input  wire logic [15:0] rsp_red_out,
   input  wire logic [15:0] rsp_green_out,
   input  wire logic [15:0] rsp_blue_out,
   input  wire logic [15:0] rsp_alpha_out,
   input  wire logic        csr_write_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending_count,
   output int               pixels_checked
);

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] alpha;
   } pixel_type;

   pixel_type   expected_pixels[$];

   logic [15:0] amount_q;
   logic [31:0] seed_q;
   logic [31:0] frame_q;
   logic        per_ch_q;
   logic [12:0] x_start_q, x_end_q, y_start_q, y_end_q;

   function automatic logic [31:0] coord_hash(input logic [63:0] col, input logic [63:0] row);
      logic [63:0] h;
      h = col;
      h = h * hpn_pkg::MIX_A + row;
      h = h * hpn_pkg::MIX_B + 64'(seed_q);
      h = h * hpn_pkg::MIX_C + 64'(frame_q);
      h = h ^ (h >> 30);
      h = h * hpn_pkg::MIX_B;
      h = h ^ (h >> 27);
      h = h * hpn_pkg::MIX_C;
      h = h ^ (h >> 31);
      return h[31:0];
   endfunction

   function automatic logic [15:0] noisy_channel(input logic [15:0] c, input logic [31:0] hash,
                                                 input logic [15:0] alpha);
      logic [63:0] twice, mag, prod, den, q;
      logic        neg;
      twice = 64'(hash[31:8]) * 2;
      neg   = twice < 64'hFFFFFF;
      mag   = neg ? 64'hFFFFFF - twice : twice - 64'hFFFFFF;
      prod  = mag * 64'(amount_q) * 64'(alpha);
      den   = 64'hFFFFFF * 64'd32768;
      q     = (prod + den / 2) / den;
      if (neg) return (q >= 64'(c)) ? 16'd0 : 16'(64'(c) - q);
      return (64'(c) + q > 64'd65535) ? 16'hFFFF : 16'(64'(c) + q);
   endfunction

   function automatic pixel_type predict_pixel();
      pixel_type p;
      logic [31:0] h;
      logic [63:0] x3;
      p = {req_red_in, req_green_in, req_blue_in, req_alpha_in};
      if ({1'b0, req_pixel_x} >= x_start_q && {1'b0, req_pixel_x} < x_end_q &&
          {1'b0, req_pixel_y} >= y_start_q && {1'b0, req_pixel_y} < y_end_q &&
          req_alpha_in != 0 && amount_q != 0) begin
         if (per_ch_q) begin
            x3 = 64'(req_pixel_x) * 3;
            p.red   = noisy_channel(p.red, coord_hash(x3, 64'(req_pixel_y)), p.alpha);
            p.green = noisy_channel(p.green, coord_hash(x3 + 1, 64'(req_pixel_y)), p.alpha);
            p.blue  = noisy_channel(p.blue, coord_hash(x3 + 2, 64'(req_pixel_y)), p.alpha);
         end else begin
            h = coord_hash(64'(req_pixel_x), 64'(req_pixel_y));
            p.red   = noisy_channel(p.red, h, p.alpha);
            p.green = noisy_channel(p.green, h, p.alpha);
            p.blue  = noisy_channel(p.blue, h, p.alpha);
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin
      pixel_type want, got;
      if (reset) begin
         amount_q  <= '0;
         seed_q    <= '0;
         frame_q   <= '0;
         per_ch_q  <= 1'b0;
         x_start_q <= '0;
         x_end_q   <= 13'd4096;
         y_start_q <= '0;
         y_end_q   <= 13'd4096;
         expected_pixels.delete();
         fail_count     <= 0;
         pixels_checked <= 0;
         pending_count  <= 0;
      end else begin
         // Registers are written only while idle, so ordering against
         // pixel predictions on the same edge does not arise.
         if (csr_write_en) begin
            case (csr_index)
               hpn_pkg::REG_AMOUNT:  amount_q  <= csr_wdata[15:0];
               hpn_pkg::REG_SEED:    seed_q    <= csr_wdata;
               hpn_pkg::REG_FRAME:   frame_q   <= csr_wdata;
               hpn_pkg::REG_PER_CH:  per_ch_q  <= csr_wdata[0];
               hpn_pkg::REG_X_START: x_start_q <= csr_wdata[12:0];
               hpn_pkg::REG_X_END:   x_end_q   <= csr_wdata[12:0];
               hpn_pkg::REG_Y_START: y_start_q <= csr_wdata[12:0];
               hpn_pkg::REG_Y_END:   y_end_q   <= csr_wdata[12:0];
               default: ;
            endcase
         end
         if (start && !busy) expected_pixels.push_back(predict_pixel());
         if (rsp_valid) begin
            got = {rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out};
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10) $display("unexpected result pixel %h", got);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_pixels.pop_front();
               pixels_checked <= pixels_checked + 1;
               if (want != got) begin
                  if (fail_count < 10)
                     $display("mismatch: expected r %h g %h b %h a %h, got r %h g %h b %h a %h",
                              want.red, want.green, want.blue, want.alpha,
                              got.red, got.green, got.blue, got.alpha);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_pixels.size();
      end
   end

endmodule

/* test/tb_hash_pixel_noise.sv */
// ----------------------------------------------------------------------------
// tb_hash_pixel_noise: testbench top for the hash pixel noise block
// Drives directed and random pixel transfers under several register settings
// and idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hash_pixel_noise;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [11:0] req_pixel_x, req_pixel_y;
   logic [15:0] req_red_in, req_green_in, req_blue_in, req_alpha_in;
   logic        rsp_valid;
   logic [15:0] rsp_red_out, rsp_green_out, rsp_blue_out, rsp_alpha_out;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count, pending_count, pixels_checked;
   int          cycle_count = 0;
   int          sender_idle_pct;

   // Extra idle margin after the pipeline drains, before any register write.
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 200000;

   hash_pixel_noise DUT (
      .clock, .reset, .start, .busy,
      .req_pixel_x, .req_pixel_y, .req_red_in, .req_green_in, .req_blue_in, .req_alpha_in,
      .rsp_valid, .rsp_red_out, .rsp_green_out, .rsp_blue_out, .rsp_alpha_out,
      .csr_write_en, .csr_index, .csr_wdata
   );

   hpn_checker u_checker (
      .clock, .reset, .start, .busy,
      .req_pixel_x, .req_pixel_y, .req_red_in, .req_green_in, .req_blue_in, .req_alpha_in,
      .rsp_valid, .rsp_red_out, .rsp_green_out, .rsp_blue_out, .rsp_alpha_out,
      .csr_write_en, .csr_index, .csr_wdata,
      .fail_count, .pending_count, .pixels_checked
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // The watchdog ends the run with a failure once the cycle limit is passed.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // One pixel transfer. Start stays high through back-to-back transfers, so it
   // is only lowered when an idle cycle is actually wanted.
   task automatic send_pixel(input logic [11:0] x, input logic [11:0] y, input logic [15:0] r,
                             input logic [15:0] g, input logic [15:0] b, input logic [15:0] a);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start        <= 1'b1;
      req_pixel_x  <= x;
      req_pixel_y  <= y;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      req_alpha_in <= a;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Lets every pixel in flight come back before the registers change.
   task automatic drain_pipeline();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input hpn_pkg::csr_index_type idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_window(input int xs, input int xe, input int ys, input int ye);
      write_reg(hpn_pkg::REG_X_START, xs);
      write_reg(hpn_pkg::REG_X_END, xe);
      write_reg(hpn_pkg::REG_Y_START, ys);
      write_reg(hpn_pkg::REG_Y_END, ye);
   endtask

   // Random pixel: mostly well-formed premultiplied colour, sometimes raw noise
   // with colour above alpha, and now and then zero or full alpha.
   task automatic send_random_pixel();
      logic [15:0] a;
      int          pick;
      pick = $urandom_range(9);
      a = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      if (pick == 2)
         send_pixel(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom),
                    16'($urandom), a);
      else
         send_pixel(12'($urandom), 12'($urandom), 16'($urandom_range(a)),
                    16'($urandom_range(a)), 16'($urandom_range(a)), a);
   endtask

   initial begin
      int phase;
      sender_idle_pct = 0;
      reset        = 1'b1;
      start        = 1'b0;
      req_pixel_x  = '0;
      req_pixel_y  = '0;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      req_alpha_in = '0;
      csr_write_en = 1'b0;
      csr_index    = hpn_pkg::REG_AMOUNT;
      csr_wdata    = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: amount zero, so everything passes through.
      send_pixel(12'd5, 12'd7, 16'h1234, 16'h5678, 16'h9ABC, 16'hFFFF);
      drain_pipeline();

      // Full strength grey noise over the whole frame, including extremes.
      write_reg(hpn_pkg::REG_AMOUNT, 32'd32768);
      write_reg(hpn_pkg::REG_SEED, 32'hFFFFFFFF);
      write_reg(hpn_pkg::REG_FRAME, 32'hFFFFFFFF);
      write_reg(hpn_pkg::REG_PER_CH, 32'd0);
      send_pixel(12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
      send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_pixel(12'd100, 12'd200, 16'h8000, 16'h4000, 16'h2000, 16'h8000);
      send_pixel(12'd100, 12'd200, 16'h8000, 16'h4000, 16'h2000, 16'h0000); // zero alpha
      send_pixel(12'd3, 12'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0100); // colour above alpha
      drain_pipeline();

      // Per-channel noise, strongest amount, and a clip window with edge pixels.
      write_reg(hpn_pkg::REG_PER_CH, 32'd1);
      write_reg(hpn_pkg::REG_AMOUNT, 32'h0000FFFF);
      set_window(10, 20, 30, 40);
      send_pixel(12'd9, 12'd35, 16'h7000, 16'h7000, 16'h7000, 16'hF000);
      send_pixel(12'd10, 12'd35, 16'h7000, 16'h7000, 16'h7000, 16'hF000);
      send_pixel(12'd19, 12'd35, 16'h7000, 16'h7000, 16'h7000, 16'hF000);
      send_pixel(12'd20, 12'd35, 16'h7000, 16'h7000, 16'h7000, 16'hF000);
      send_pixel(12'd15, 12'd29, 16'h7000, 16'h7000, 16'h7000, 16'hF000);
      send_pixel(12'd15, 12'd30, 16'h7000, 16'h7000, 16'h7000, 16'hF000);
      send_pixel(12'd15, 12'd39, 16'h7000, 16'h7000, 16'h7000, 16'hF000);
      send_pixel(12'd15, 12'd40, 16'h7000, 16'h7000, 16'h7000, 16'hF000);
      drain_pipeline();

      // Inverted window: nothing inside.
      set_window(4096, 0, 4096, 0);
      send_pixel(12'd0, 12'd0, 16'h1000, 16'h2000, 16'h3000, 16'hFFFF);
      send_pixel(12'hFFF, 12'hFFF, 16'h1000, 16'h2000, 16'h3000, 16'hFFFF);
      drain_pipeline();

      // Random phases: each rewrites the registers and sets an idle pattern.
      for (phase = 0; phase < 8; phase++) begin
         write_reg(hpn_pkg::REG_AMOUNT, (phase == 0) ? 32'd1 : (phase == 1) ? 32'd32768 :
                                        (phase == 2) ? 32'd0 : (phase == 3) ? 32'h0000FFFF :
                                        $urandom);
         write_reg(hpn_pkg::REG_SEED, $urandom);
         write_reg(hpn_pkg::REG_FRAME, (phase == 4) ? 32'd0 : $urandom);
         write_reg(hpn_pkg::REG_PER_CH, 32'(phase % 2));
         if (phase % 3 == 2)
            set_window($urandom_range(4096), $urandom_range(4096),
                       $urandom_range(4096), $urandom_range(4096));
         else
            set_window(0, 4096, 0, 4096);
         case (phase % 4)
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 53;
            2: sender_idle_pct = 0;
            default: sender_idle_pct = 11;
         endcase
         repeat (150) send_random_pixel();
         // The sender then holds off until every result is back.
         drain_pipeline();
      end

      drain_pipeline();
      $display("covered %0d checked pixels over grey and per-channel noise, clip windows,",
               pixels_checked);
      $display("zero, unit and maximum amounts, and idle and back-to-back pixel streams");
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
